// ----- hdl/idba_pkg.sv -----
package idba_pkg;

    localparam int IDENT_W = 12;
    localparam int BYTE_W  = 8;
    localparam int BIT_W   = 3;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_QUERY = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_FREE,
        ST_POP,
        ST_POP_CHK,
        ST_SCAN,
        ST_SCAN_CHK
    } state_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } find_t;

endpackage

// ----- hdl/idba_find.sv -----
module idba_find
    import idba_pkg::*;
(
    input  logic [BYTE_W-1:0] avail,
    output find_t             res
);

    // lowest available bit wins
    always_comb
    begin
        res = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                res.found = 1'b1;
                res.pos   = BIT_W'(i);
            end
        end
    end

endmodule

// ----- hdl/id_bitmap_allocator.sv -----
// Identifier allocator: hands out identifiers below ID_LIMIT and takes them back.
// Command channel: func and ident are taken at a clock edge where start is high and
// busy is low. func selects allocate, free or in-use query; ident is ignored for
// allocate. Each command gives exactly one result: done is high for one cycle with
// ok and ident_out valid; the receiver cannot stall, so results are never held.
// Used identifiers live in a byte-wide bitmap memory (one read, one write port,
// registered read); freed identifiers go to a recycle stack memory.
// Allocate first pops the recycle stack, skipping stale entries whose bitmap bit
// is set; with the stack empty it scans the bitmap from the scan pointer, one
// byte per read, and the whole byte is searched at once. Free and query read the
// identifier's bitmap byte and then answer.
// busy falls in the cycle done is shown, so a new command can follow at once.
// After reset the bitmap is initialized by a clearing pass over all its bytes,
// during which busy stays high.
module id_bitmap_allocator
    import idba_pkg::*;
#(
    parameter int ID_LIMIT      = 4096,
    parameter int POOL_DEPTH    = 64,
    parameter int FIRST_ID      = 1,
    parameter int RESERVED_MASK = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         func,
    input  logic [IDENT_W-1:0] ident,
    output logic               busy,
    output logic               done,
    output logic               ok,
    output logic [IDENT_W-1:0] ident_out
);

    localparam int MAP_BYTES = (ID_LIMIT + 7) / 8;
    localparam int AW        = $clog2(MAP_BYTES);
    localparam int ID_W      = $clog2(ID_LIMIT + 1);
    localparam int XW        = ((ID_W > IDENT_W) ? ID_W : IDENT_W) + 1;
    localparam int STK_SLOTS = POOL_DEPTH + 1;
    localparam int CW        = $clog2(STK_SLOTS);
    localparam logic [XW-1:0]     LIMIT_X   = XW'(ID_LIMIT);
    localparam logic [BYTE_W-1:0] RSV_BYTE  = BYTE_W'(RESERVED_MASK);
    localparam logic [BYTE_W-1:0] TAIL_MASK = ((ID_LIMIT % 8) == 0) ? 8'hFF :
                                              BYTE_W'((1 << (ID_LIMIT % 8)) - 1);

    state_t             state_reg,     state_next;
    logic [AW-1:0]      clr_reg,       clr_next;
    logic [IDENT_W-1:0] ident_reg,     ident_next;
    logic [IDENT_W-1:0] cand_reg,      cand_next;
    logic [XW-1:0]      probe_reg,     probe_next;
    logic [XW-1:0]      scan_base_reg, scan_base_next;
    logic [XW-1:0]      pool_min_reg,  pool_min_next;
    logic [CW-1:0]      count_reg,     count_next;
    logic               done_reg,      done_next;
    logic               ok_reg,        ok_next;
    logic [IDENT_W-1:0] id_out_reg,    id_out_next;

    logic [BYTE_W-1:0]  map_mem [MAP_BYTES];
    logic [BYTE_W-1:0]  map_rd_reg;
    logic               map_we;
    logic [AW-1:0]      map_waddr;
    logic [AW-1:0]      map_raddr;
    logic [BYTE_W-1:0]  map_wdata;

    logic [IDENT_W-1:0] stk_mem [STK_SLOTS];
    logic [IDENT_W-1:0] stk_rd_reg;
    logic               stk_we;
    logic [CW-1:0]      stk_waddr;
    logic [CW-1:0]      stk_raddr;

    logic [XW-1:0]      id_in_x;
    logic [XW-1:0]      id_reg_x;
    logic [XW-1:0]      cand_x;
    logic [XW-1:0]      stk_x;
    logic [XW-1:0]      probe_step;
    logic [XW-1:0]      gid_x;
    logic [XW-1:0]      free_min;
    logic               id_ok;
    logic               cur_bit;
    logic [BYTE_W-1:0]  tail_mask;
    logic [BYTE_W-1:0]  avail;
    find_t              hit;

    assign id_in_x    = XW'(ident);
    assign id_reg_x   = XW'(ident_reg);
    assign cand_x     = XW'(cand_reg);
    assign stk_x      = XW'(stk_rd_reg);
    assign id_ok      = id_reg_x < LIMIT_X;
    assign cur_bit    = map_rd_reg[id_reg_x[BIT_W-1:0]];
    assign free_min   = (id_reg_x < pool_min_reg) ? id_reg_x : pool_min_reg;
    assign probe_step = {probe_reg[XW-1:BIT_W], {BIT_W{1'b0}}} + XW'(BYTE_W);
    assign gid_x      = {probe_reg[XW-1:BIT_W], hit.pos};
    assign tail_mask  = (probe_reg[AW+2:3] == AW'(MAP_BYTES - 1)) ? TAIL_MASK : '1;
    assign avail      = ~map_rd_reg & (8'hFF << probe_reg[BIT_W-1:0]) & tail_mask;

    idba_find u_find
    (
        .avail (avail),
        .res   (hit)
    );

    // bitmap memory
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rd_reg <= map_mem[map_raddr];
    end

    // recycle stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= ident_reg;
        end
        stk_rd_reg <= stk_mem[stk_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            scan_base_reg <= XW'(FIRST_ID);
            pool_min_reg  <= LIMIT_X;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            scan_base_reg <= scan_base_next;
            pool_min_reg  <= pool_min_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ident_reg  <= ident_next;
        cand_reg   <= cand_next;
        probe_reg  <= probe_next;
        ok_reg     <= ok_next;
        id_out_reg <= id_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        ident_next     = ident_reg;
        cand_next      = cand_reg;
        probe_next     = probe_reg;
        scan_base_next = scan_base_reg;
        pool_min_next  = pool_min_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        ok_next        = 1'b0;
        id_out_next    = '0;
        map_we         = 1'b0;
        map_waddr      = clr_reg;
        map_wdata      = '0;
        map_raddr      = probe_reg[AW+2:3];
        stk_we         = 1'b0;
        stk_waddr      = count_reg;
        stk_raddr      = count_reg - CW'(1);

        case (state_reg)
            ST_CLEAR:
            begin
                map_we    = 1'b1;
                map_wdata = (clr_reg == '0) ? RSV_BYTE : '0;
                if (clr_reg == AW'(MAP_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                map_raddr = id_in_x[AW+2:3];
                if (start)
                begin
                    ident_next = ident;
                    case (func)
                        FUNC_ALLOC:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CW'(1);
                                state_next = ST_POP;
                            end
                            else
                            begin
                                probe_next = scan_base_reg;
                                state_next = ST_SCAN;
                            end
                        end
                        FUNC_FREE:  state_next = ST_FREE;
                        FUNC_QUERY: state_next = ST_QUERY;
                        default:    done_next  = 1'b1;
                    endcase
                end
            end
            ST_QUERY:
            begin
                done_next  = 1'b1;
                ok_next    = id_ok && cur_bit;
                state_next = ST_IDLE;
            end
            ST_FREE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (id_ok && cur_bit)
                begin
                    ok_next   = 1'b1;
                    map_we    = 1'b1;
                    map_waddr = id_reg_x[AW+2:3];
                    map_wdata = map_rd_reg & ~(8'd1 << id_reg_x[BIT_W-1:0]);
                    stk_we    = 1'b1;
                    // stack full: discard the whole stack and pull the scan back to the lowest freed identifier
                    if (count_reg == CW'(POOL_DEPTH))
                    begin
                        if (free_min < scan_base_reg)
                        begin
                            scan_base_next = free_min;
                        end
                        count_next    = '0;
                        pool_min_next = LIMIT_X;
                    end
                    else
                    begin
                        count_next    = count_reg + CW'(1);
                        pool_min_next = free_min;
                    end
                end
            end
            ST_POP:
            begin
                cand_next  = stk_rd_reg;
                map_raddr  = stk_x[AW+2:3];
                state_next = ST_POP_CHK;
            end
            ST_POP_CHK:
            begin
                if (!map_rd_reg[cand_x[BIT_W-1:0]])
                begin
                    map_we      = 1'b1;
                    map_waddr   = cand_x[AW+2:3];
                    map_wdata   = map_rd_reg | (8'd1 << cand_x[BIT_W-1:0]);
                    done_next   = 1'b1;
                    ok_next     = 1'b1;
                    id_out_next = cand_reg;
                    state_next  = ST_IDLE;
                end
                else if (count_reg != '0)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_POP;
                end
                else
                begin
                    probe_next = scan_base_reg;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (probe_reg >= LIMIT_X)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (hit.found)
                begin
                    map_we         = 1'b1;
                    map_waddr      = probe_reg[AW+2:3];
                    map_wdata      = map_rd_reg | (8'd1 << hit.pos);
                    scan_base_next = gid_x + XW'(1);
                    done_next      = 1'b1;
                    ok_next        = 1'b1;
                    id_out_next    = gid_x[IDENT_W-1:0];
                    state_next     = ST_IDLE;
                end
                else if (probe_step >= LIMIT_X)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    probe_next = probe_step;
                    map_raddr  = probe_step[AW+2:3];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign ok        = ok_reg;
    assign ident_out = id_out_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_QUERY) |-> ##2 done)
        else $error("query result not delivered two cycles after accept");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (ident_out == '0))
        else $error("failed command returned a nonzero identifier");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_base_reg <= LIMIT_X || scan_base_reg == XW'(FIRST_ID))
        else $error("scan pointer beyond identifier limit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(POOL_DEPTH))
        else $error("recycle stack count beyond pool depth");
`endif

endmodule
